@@ design/cbp_pkg.sv @@
// ----------------------------------------------------------------------------
// cbp_pkg: shared types and constants of the cubic curve plotter
// Step index width, register reset value, coordinate count and sequencer states.
// ----------------------------------------------------------------------------
package cbp_pkg;

  // step index and segment count width
  localparam int unsigned IDX_W = 6;

  // segments per curve after reset
  localparam logic [IDX_W-1:0] SEG_RESET = 6'd16;

  // coordinates held per request: x and y of four points
  localparam int unsigned NUM_COORDS = 8;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_DIV,
    SEQ_ISSUE
  } seq_state_e;

endpackage

@@ design/cbp_step_div.sv @@
// ----------------------------------------------------------------------------
// cbp_step_div: step size divider
// Restoring division of 2^FRAC_BITS by the segment count, one quotient bit
// per cycle. Quotient and remainder hold after done until the next start.
// ----------------------------------------------------------------------------
module cbp_step_div #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [cbp_pkg::IDX_W-1:0]    divisor_i,
  output logic                         done_o,
  output logic [FRAC_BITS:0]           quot_o,
  output logic [cbp_pkg::IDX_W-1:0]    rem_o
);

  localparam int unsigned TW    = FRAC_BITS + 1;
  localparam int unsigned CNT_W = $clog2(FRAC_BITS + 1);
  localparam int unsigned IW    = cbp_pkg::IDX_W;

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [IW-1:0]    div_q;
  logic [IW-1:0]    rem_q, rem_d;
  logic [TW-1:0]    quot_q;
  logic [IW:0]      trial;
  logic             ge;

  // dividend is a single one at bit FRAC_BITS
  always_comb begin
    trial = {rem_q, (cnt_q == CNT_W'(FRAC_BITS))};
    ge    = (trial >= {1'b0, div_q});
    rem_d = ge ? IW'(trial - {1'b0, div_q}) : trial[IW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(FRAC_BITS);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q  <= divisor_i;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      quot_q <= {quot_q[TW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

@@ design/cubic_bezier_plotter.sv @@
// ----------------------------------------------------------------------------
// cubic_bezier_plotter: samples a cubic curve at evenly spaced steps
// One request of four Q12.4 points gives segment_count + 1 points along the
// curve, weighted with rounded Bernstein weights and saturated.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  eight coordinates, one request
// m_axis    out  m_axis_tvalid/m_axis_tready  point x, y, index; tlast = last
// cfg       in   cfg_wen_i                    segment_count (0 counts as 1)
//
// Flow: a request first works out the step size (bit-serial divider),
// then issues one point per cycle while m_axis is not stalled, n + 1
// points in all, into a six-stage point pipeline. The next request is
// taken once the sequencer is idle and the first three stages have
// drained. Reset clears all valid bits and the sequencer.
// Back-pressure on m_axis freezes every stage together; nothing is dropped.
// ----------------------------------------------------------------------------
module cubic_bezier_plotter #(
  parameter int unsigned COORD_WIDTH = 16,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // start_x, start_y, ctrl_one_x, ctrl_one_y, finish_x, finish_y,
  // ctrl_two_x, ctrl_two_y (lowest first)
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [8*COORD_WIDTH-1:0]          s_axis_tdata,
  // point_x, point_y, point_index, zero fill (lowest first)
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [((2*COORD_WIDTH+cbp_pkg::IDX_W+7)/8)*8-1:0] m_axis_tdata,
  output logic                              m_axis_tlast,
  input  logic                              cfg_wen_i,
  input  logic [cbp_pkg::IDX_W-1:0]         cfg_wdata_i
);

  localparam int unsigned CW    = COORD_WIDTH;
  localparam int unsigned F     = FRAC_BITS;
  localparam int unsigned IW    = cbp_pkg::IDX_W;
  localparam int unsigned TW    = F + 1;        // t, u and raw weights
  localparam int unsigned WW    = F + 2;        // weights times three
  localparam int unsigned PW    = WW + 1 + CW;  // signed weight x coordinate
  localparam int unsigned SW    = PW + 2;       // sum of four products
  localparam int unsigned OUT_W = ((2*CW + IW + 7)/8)*8;

  localparam logic [TW-1:0]        ONE    = TW'(1) << F;
  localparam logic [2*TW-1:0]      HALF_P = (2*TW)'(1) << (F - 1);
  localparam logic signed [SW-1:0] HALF_S = SW'(1) << (F - 1);
  localparam logic [CW-1:0]        SAT_HI = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0]        SAT_LO = {1'b1, {(CW-1){1'b0}}};

  // rounded fixed point product at F fractional bits
  function automatic logic [TW-1:0] rnd_mul(input logic [TW-1:0] a,
                                            input logic [TW-1:0] b);
    logic [2*TW-1:0] p;
    p = a * b + HALF_P;
    return p[F+TW-1:F];
  endfunction

  // ---------------------------------------------------------------- config
  logic [IW-1:0] seg_q;
  logic [IW-1:0] n_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q <= cbp_pkg::SEG_RESET;
    end else if (cfg_wen_i) begin
      seg_q <= cfg_wdata_i;
    end
  end

  // a count of zero runs as one segment
  assign n_eff = (seg_q == '0) ? IW'(1) : seg_q;

  // ------------------------------------------------------------- sequencer
  cbp_pkg::seq_state_e state_q, state_d;

  logic                 adv;          // whole pipeline moves
  logic                 in_acc;
  logic                 issue_fire;
  logic                 div_start;
  logic                 div_done;
  logic [TW-1:0]        div_quot;
  logic [IW-1:0]        div_rem;
  logic [IW-1:0]        n_q;
  logic [IW-1:0]        step_q;
  logic [TW-1:0]        acc_q;        // t of the next step
  logic [IW-1:0]        frac_q;       // running remainder of t, below n
  logic [IW:0]          frac_sum;
  logic                 frac_wrap;
  logic                 last_step;

  logic signed [CW-1:0] held_q [cbp_pkg::NUM_COORDS];

  logic v0_q, v1_q, v2_q, v3_q, v4_q, vo_q;

  assign adv        = !vo_q || m_axis_tready;
  assign s_axis_tready = (state_q == cbp_pkg::SEQ_IDLE) && !v0_q && !v1_q && !v2_q;
  assign in_acc     = s_axis_tvalid && s_axis_tready;
  assign issue_fire = (state_q == cbp_pkg::SEQ_ISSUE) && adv;
  assign last_step  = (step_q == n_q);

  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    unique case (state_q)
      cbp_pkg::SEQ_IDLE: begin
        if (in_acc) begin
          div_start = 1'b1;
          state_d   = cbp_pkg::SEQ_DIV;
        end
      end
      cbp_pkg::SEQ_DIV: begin
        if (div_done) state_d = cbp_pkg::SEQ_ISSUE;
      end
      cbp_pkg::SEQ_ISSUE: begin
        if (issue_fire && last_step) state_d = cbp_pkg::SEQ_IDLE;
      end
      default: state_d = cbp_pkg::SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cbp_pkg::SEQ_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  cbp_step_div #(
    .FRAC_BITS (F)
  ) u_step_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .divisor_i (n_eff),
    .done_o    (div_done),
    .quot_o    (div_quot),
    .rem_o     (div_rem)
  );

  // t_i = round(i * 2^F / n) kept as quotient plus remainder; each step
  // adds 2^F / n and carries once the remainder reaches n
  assign frac_sum  = {1'b0, frac_q} + {1'b0, div_rem};
  assign frac_wrap = (frac_sum >= {1'b0, n_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if ((state_q == cbp_pkg::SEQ_DIV) && div_done) begin
      step_q <= '0;
    end else if (issue_fire) begin
      step_q <= step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      n_q <= n_eff;
      for (int k = 0; k < cbp_pkg::NUM_COORDS; k++) begin
        held_q[k] <= s_axis_tdata[k*CW +: CW];
      end
    end
    if ((state_q == cbp_pkg::SEQ_DIV) && div_done) begin
      acc_q  <= '0;
      frac_q <= n_q >> 1;       // rounding offset of n/2
    end else if (issue_fire) begin
      acc_q  <= acc_q + div_quot + TW'(frac_wrap);
      frac_q <= frac_wrap ? IW'(frac_sum - {1'b0, n_q}) : frac_sum[IW-1:0];
    end
  end

  // -------------------------------------------------------------- pipeline
  // S0 t | S1 t^2, u^2, tu | S2 weights | S3 weight x coord | S4 sum | out
  logic [TW-1:0]        t0_q;
  logic [IW-1:0]        idx0_q, idx1_q, idx2_q, idx3_q, idx4_q, idxo_q;
  logic                 last0_q, last1_q, last2_q, last3_q, last4_q, lasto_q;

  logic [TW-1:0]        u0;
  logic [TW-1:0]        t1_q, u1_q, tt1_q, uu1_q, tu1_q;
  logic [TW-1:0]        wa_r, wb_r, wc_r, wd_r;
  logic [WW-1:0]        wa2_q, wb2_q, wc2_q, wd2_q;
  logic signed [WW:0]   wa_s, wb_s, wc_s, wd_s;
  logic signed [PW-1:0] pa3_q [2];
  logic signed [PW-1:0] pb3_q [2];
  logic signed [PW-1:0] pc3_q [2];
  logic signed [PW-1:0] pd3_q [2];
  logic signed [SW-1:0] sum4_q [2];
  logic [CW-1:0]        sat_d [2];
  logic [CW-1:0]        pnt_q [2];

  assign u0 = ONE - t0_q;

  assign wa_r = rnd_mul(uu1_q, u1_q);
  assign wb_r = rnd_mul(tu1_q, u1_q);
  assign wc_r = rnd_mul(tt1_q, u1_q);
  assign wd_r = rnd_mul(tt1_q, t1_q);

  assign wa_s = {1'b0, wa2_q};
  assign wb_s = {1'b0, wb2_q};
  assign wc_s = {1'b0, wc2_q};
  assign wd_s = {1'b0, wd2_q};

  // arithmetic shift by F, then clamp when the high bits disagree
  always_comb begin
    for (int c = 0; c < 2; c++) begin
      if ((&sum4_q[c][SW-1:F+CW-1]) || !(|sum4_q[c][SW-1:F+CW-1])) begin
        sat_d[c] = sum4_q[c][F+CW-1:F];
      end else begin
        sat_d[c] = sum4_q[c][SW-1] ? SAT_LO : SAT_HI;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (adv) begin
      v0_q <= issue_fire;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      vo_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t0_q    <= acc_q;
      idx0_q  <= step_q;
      last0_q <= last_step;

      t1_q    <= t0_q;
      u1_q    <= u0;
      tt1_q   <= rnd_mul(t0_q, t0_q);
      uu1_q   <= rnd_mul(u0, u0);
      tu1_q   <= rnd_mul(t0_q, u0);
      idx1_q  <= idx0_q;
      last1_q <= last0_q;

      wa2_q   <= {1'b0, wa_r};
      wb2_q   <= {1'b0, wb_r} + {wb_r, 1'b0};
      wc2_q   <= {1'b0, wc_r} + {wc_r, 1'b0};
      wd2_q   <= {1'b0, wd_r};
      idx2_q  <= idx1_q;
      last2_q <= last1_q;

      for (int c = 0; c < 2; c++) begin
        pa3_q[c]  <= wa_s * held_q[c];
        pb3_q[c]  <= wb_s * held_q[2 + c];
        pd3_q[c]  <= wd_s * held_q[4 + c];
        pc3_q[c]  <= wc_s * held_q[6 + c];
        sum4_q[c] <= pa3_q[c] + pb3_q[c] + pc3_q[c] + pd3_q[c] + HALF_S;
        pnt_q[c]  <= sat_d[c];
      end
      idx3_q  <= idx2_q;
      last3_q <= last2_q;
      idx4_q  <= idx3_q;
      last4_q <= last3_q;
      idxo_q  <= idx4_q;
      lasto_q <= last4_q;
    end
  end

  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = OUT_W'({idxo_q, pnt_q[1], pnt_q[0]});
  assign m_axis_tlast  = lasto_q;

endmodule

@@ design/cbp_checker.sv @@
// ----------------------------------------------------------------------------
// cbp_checker: port level checks of the cubic curve plotter
// Watches handshakes and point numbering; bound to the top level.
// ----------------------------------------------------------------------------
module cbp_checker #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [((2*COORD_WIDTH+cbp_pkg::IDX_W+7)/8)*8-1:0] m_axis_tdata,
  input logic                              m_axis_tlast,
  input logic                              cfg_wen_i,
  input logic [cbp_pkg::IDX_W-1:0]         cfg_wdata_i
);

  localparam int unsigned IW = cbp_pkg::IDX_W;

  logic [IW-1:0] seg_q;
  logic [IW-1:0] n_eff;
  logic [IW-1:0] out_idx;
  logic          out_acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q <= cbp_pkg::SEG_RESET;
    end else if (cfg_wen_i) begin
      seg_q <= cfg_wdata_i;
    end
  end

  assign n_eff   = (seg_q == '0) ? IW'(1) : seg_q;
  assign out_idx = m_axis_tdata[2*COORD_WIDTH +: IW];
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // stalled point holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled output point changed");

  // a new request is not taken straight after one
  a_one_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while previous one starts");

  // a curve has at least two points
  a_first_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && (out_idx == '0) |-> !m_axis_tlast)
    else $error("first point flagged as last");

  // the last point carries the segment count as its index
  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && m_axis_tlast |-> (out_idx == n_eff))
    else $error("last point index differs from segment count");

endmodule

bind cubic_bezier_plotter cbp_checker #(
  .COORD_WIDTH (COORD_WIDTH)
) u_cbp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .cfg_wen_i     (cfg_wen_i),
  .cfg_wdata_i   (cfg_wdata_i)
);

@@ tb/sv/bezier_point_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bezier_point_checker: predicts and checks the curve plotter's points
// Watches the request, point and register channels. Each accepted request is
// expanded into its expected points, and each accepted point is compared
// field by field with the oldest one that is still waiting.
// ----------------------------------------------------------------------------
module bezier_point_checker #(
  parameter int unsigned COORD_WIDTH = 16,
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned OUT_W       = ((2*COORD_WIDTH+cbp_pkg::IDX_W+7)/8)*8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  input  logic                         s_axis_tready_i,
  input  logic [8*COORD_WIDTH-1:0]     s_axis_tdata_i,
  input  logic                         m_axis_tvalid_i,
  input  logic                         m_axis_tready_i,
  input  logic [OUT_W-1:0]             m_axis_tdata_i,
  input  logic                         m_axis_tlast_i,
  input  logic                         cfg_wen_i,
  input  logic [cbp_pkg::IDX_W-1:0]    cfg_wdata_i,
  output int unsigned                  pending_points_o,
  output int unsigned                  mismatches_o
);

  localparam int unsigned IW = cbp_pkg::IDX_W;

  localparam longint ONE   = longint'(1) << FRAC_BITS;
  localparam longint HALF  = longint'(1) << (FRAC_BITS - 1);
  localparam longint C_MAX = (longint'(1) << (COORD_WIDTH - 1)) - 1;
  localparam longint C_MIN = -C_MAX - 1;

  typedef struct packed {
    logic [COORD_WIDTH-1:0] x;
    logic [COORD_WIDTH-1:0] y;
    logic [IW-1:0]          idx;
    logic                   last;
  } curve_point_t;

  curve_point_t       expected_points[$];
  logic [IW-1:0]      segments;

  initial mismatches_o = 0;

  function automatic longint round_product(longint a, longint b);
    return (a * b + HALF) >>> FRAC_BITS;
  endfunction

  function automatic logic [COORD_WIDTH-1:0] clamp_coord(longint v);
    longint c;
    c = (v > C_MAX) ? C_MAX : ((v < C_MIN) ? C_MIN : v);
    return c[COORD_WIDTH-1:0];
  endfunction

  // expand one request into its n + 1 points
  task automatic plot_curve(input logic [8*COORD_WIDTH-1:0] req);
    longint       pt[8];
    longint       n, t, u, t2, u2, tu;
    longint       w_start, w_one, w_two, w_finish, acc;
    logic [COORD_WIDTH-1:0] axis_val[2];
    curve_point_t p;
    n = (segments == '0) ? 1 : longint'(segments);
    for (int k = 0; k < 8; k++) begin
      pt[k] = longint'($signed(req[k*COORD_WIDTH +: COORD_WIDTH]));
    end
    for (longint i = 0; i <= n; i++) begin
      t  = ((i << FRAC_BITS) + (n >> 1)) / n;
      u  = ONE - t;
      t2 = round_product(t, t);
      u2 = round_product(u, u);
      tu = round_product(t, u);
      w_start  = round_product(u2, u);
      w_one    = 3 * round_product(tu, u);
      w_two    = 3 * round_product(t2, u);
      w_finish = round_product(t2, t);
      // fields: start, ctrl one, finish, ctrl two; x then y
      for (int c = 0; c < 2; c++) begin
        acc = w_start * pt[c] + w_one * pt[2+c] + w_finish * pt[4+c] + w_two * pt[6+c];
        axis_val[c] = clamp_coord((acc + HALF) >>> FRAC_BITS);
      end
      p.x    = axis_val[0];
      p.y    = axis_val[1];
      p.idx  = i[IW-1:0];
      p.last = (i == n);
      expected_points.push_back(p);
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $time, what);
    mismatches_o++;
  endtask

  task automatic check_point();
    curve_point_t p;
    logic [COORD_WIDTH-1:0] got_x, got_y;
    logic [IW-1:0]          got_idx;
    got_x   = m_axis_tdata_i[0 +: COORD_WIDTH];
    got_y   = m_axis_tdata_i[COORD_WIDTH +: COORD_WIDTH];
    got_idx = m_axis_tdata_i[2*COORD_WIDTH +: IW];
    if (expected_points.size() == 0) begin
      report_mismatch($sformatf("unexpected point x=%h y=%h idx=%0d", got_x, got_y, got_idx));
    end else begin
      p = expected_points.pop_front();
      if (got_x !== p.x)
        report_mismatch($sformatf("idx %0d x: got %h want %h", p.idx, got_x, p.x));
      if (got_y !== p.y)
        report_mismatch($sformatf("idx %0d y: got %h want %h", p.idx, got_y, p.y));
      if (got_idx !== p.idx)
        report_mismatch($sformatf("point index: got %0d want %0d", got_idx, p.idx));
      if (m_axis_tlast_i !== p.last)
        report_mismatch($sformatf("idx %0d tlast: got %b want %b", p.idx, m_axis_tlast_i,
                                  p.last));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      segments = cbp_pkg::SEG_RESET;
      expected_points.delete();
      pending_points_o <= 0;
    end else begin
      if (cfg_wen_i) segments = cfg_wdata_i;
      if (s_axis_tvalid_i && s_axis_tready_i) plot_curve(s_axis_tdata_i);
      if (m_axis_tvalid_i && m_axis_tready_i) check_point();
      pending_points_o <= expected_points.size();
    end
  end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the cubic curve plotter
// Drives curve requests in random bursts across several segment counts,
// stalls the point channel on its own pattern and once for a long stretch;
// the checker beside the block predicts and compares every point.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned COORD_WIDTH = 16;
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned IW          = cbp_pkg::IDX_W;
  localparam int unsigned OUT_W       = ((2*COORD_WIDTH+IW+7)/8)*8;

  // divider plus pipeline depth, with margin
  localparam int unsigned DRAIN_CYCLES = 2*(FRAC_BITS+3) + 16;
  // longest quiet stretch tolerated: long hold-off plus divider and gaps
  localparam int unsigned HOLD_CYCLES  = 700;
  localparam int unsigned QUIET_LIMIT  = 4000;
  localparam int unsigned NUM_PHASES   = 9;
  localparam int unsigned PHASE_ITEMS  = 38;

  localparam logic [15:0] C_MAX = 16'h7FFF;
  localparam logic [15:0] C_MIN = 16'h8000;

  // one request: coordinate k sits at bits [16k +: 16]
  typedef logic [7:0][COORD_WIDTH-1:0] curve_t;

  logic                    clk_i  = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  // start_x, start_y, ctrl_one_x, ctrl_one_y, finish_x, finish_y,
  // ctrl_two_x, ctrl_two_y (lowest first)
  logic [8*COORD_WIDTH-1:0] s_axis_tdata = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  // point_x, point_y, point_index, zero fill (lowest first)
  logic [OUT_W-1:0]        m_axis_tdata;
  logic                    m_axis_tlast;
  logic                    cfg_wen_i   = 1'b0;
  logic [IW-1:0]           cfg_wdata_i = '0;

  int unsigned pending_points;
  int unsigned mismatches;

  // long hold-off requests: stimulus bumps it, receiver notices the change
  int unsigned hold_request = 0;
  int unsigned hold_seen    = 0;
  int unsigned hold_left    = 0;
  int unsigned stall_mode   = 0;
  int unsigned stall_left   = 0;
  int unsigned stall_tick   = 0;
  int unsigned quiet_cycles = 0;

  always #5 clk_i = ~clk_i;

  cubic_bezier_plotter #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_wen_i     (cfg_wen_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  bezier_point_checker #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS),
    .OUT_W       (OUT_W)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid_i  (s_axis_tvalid),
    .s_axis_tready_i  (s_axis_tready),
    .s_axis_tdata_i   (s_axis_tdata),
    .m_axis_tvalid_i  (m_axis_tvalid),
    .m_axis_tready_i  (m_axis_tready),
    .m_axis_tdata_i   (m_axis_tdata),
    .m_axis_tlast_i   (m_axis_tlast),
    .cfg_wen_i        (cfg_wen_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .pending_points_o (pending_points),
    .mismatches_o     (mismatches)
  );

  // --------------------------------------------------------------------------
  // Point receiver. Runs its own stall pattern, switching style at random
  // intervals: always ready, coin toss, a fixed repeating rhythm, or mostly
  // ready. A bumped hold_request forces a long stretch with tready low so the
  // pipeline fills and the block backs up onto its request channel.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else if (hold_request != hold_seen) begin
      hold_seen = hold_request;
      hold_left = HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(50, 300);
      end
      stall_left--;
      stall_tick++;
      case (stall_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= 1'($urandom_range(0, 1));
        2:       m_axis_tready <= ((stall_tick % 7) < 3);
        default: m_axis_tready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: any accepted item on either channel clears the count. A long
  // run with nothing accepted means the block has hung.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  function automatic curve_t curve_of(logic [15:0] sx, logic [15:0] sy,
                                      logic [15:0] ax, logic [15:0] ay,
                                      logic [15:0] fx, logic [15:0] fy,
                                      logic [15:0] bx, logic [15:0] by);
    return {by, bx, fy, fx, ay, ax, sy, sx};
  endfunction

  // half full-range values, some extremes, some modest coordinates
  function automatic logic [15:0] pick_coord();
    int unsigned style;
    style = $urandom_range(0, 19);
    if (style < 10) return 16'($urandom);
    if (style < 13) begin
      case ($urandom_range(0, 4))
        0:       return C_MAX;
        1:       return C_MIN;
        2:       return 16'h0000;
        3:       return 16'hFFFF;
        default: return 16'h0001;
      endcase
    end
    return 16'($urandom_range(0, 4095) - 2048);
  endfunction

  function automatic curve_t random_curve();
    curve_t c;
    for (int k = 0; k < 8; k++) c[k] = pick_coord();
    return c;
  endfunction

  // hold the item until taken; lower tvalid only if a gap follows, so a
  // back-to-back item never sees tvalid dropped and raised in one step
  task automatic offer_curve(input curve_t c, input int unsigned gap);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // every expected point in, then let the pipeline settle
  task automatic wait_drained();
    @(posedge clk_i);
    while (pending_points != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_segments(input logic [IW-1:0] seg);
    cfg_wen_i   <= 1'b1;
    cfg_wdata_i <= seg;
    @(posedge clk_i);
    cfg_wen_i   <= 1'b0;
  endtask

  // random bursts of 1..8 items with an idle gap of random length between bursts;
  // a steady run has no gaps except after its last item
  task automatic run_random(input int unsigned count, input bit steady);
    int unsigned burst_left;
    int unsigned gap;
    burst_left = 0;
    for (int unsigned n = 0; n < count; n++) begin
      if (burst_left == 0) burst_left = $urandom_range(1, 8);
      burst_left--;
      gap = (steady || burst_left != 0) ? 0 : $urandom_range(1, 60);
      if (n == count - 1 && gap == 0) gap = 1;
      offer_curve(random_curve(), gap);
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus. Directed curves at the reset segment count first: flat, both
  // rails, control points pulled to the opposite rail, weights overshooting
  // one at the positive rail, one-LSB rounding, bit toggles and each
  // coordinate alone at the top rail. Then phases with their own segment
  // count, including zero (taken as one), one, and the largest.
  // --------------------------------------------------------------------------
  initial begin
    logic [IW-1:0] seg;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    offer_curve(curve_of('0, '0, '0, '0, '0, '0, '0, '0), 0);
    offer_curve(curve_of(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX), 0);
    offer_curve(curve_of(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN), 3);
    offer_curve(curve_of(C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX), 0);
    offer_curve(curve_of(C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN), 0);
    offer_curve(curve_of(C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN), 7);
    offer_curve(curve_of(16'h0001, 16'hFFFF, '0, '0, '0, '0, '0, '0), 0);
    offer_curve(curve_of('0, '0, C_MAX, C_MIN, 16'h0010, 16'hFFF0, C_MIN, C_MAX), 0);
    offer_curve(curve_of(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
                         16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555), 1);
    for (int k = 0; k < 8; k++) begin
      curve_t c;
      c = {8{C_MIN}};
      c[k] = C_MAX;
      offer_curve(c, (k % 3 == 0) ? 2 : 0);
    end
    run_random(20, 1'b0);

    for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       seg = '0;
        1:       seg = 6'd1;
        2:       seg = 6'd63;
        3:       seg = 6'd2;
        4:       seg = cbp_pkg::SEG_RESET;
        5:       seg = 6'd31;
        default: seg = IW'($urandom_range(0, 63));
      endcase
      // sender pauses until the last expected point has come back
      wait_drained();
      write_segments(seg);
      if (ph == 3) begin
        // receiver holds off while requests keep coming back to back
        hold_request++;
        run_random(PHASE_ITEMS, 1'b1);
      end else begin
        run_random(PHASE_ITEMS, ph % 3 == 2);
      end
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
